@@ hw/rtl/crc_pkg.sv @@
// shared types, register indexes and reset constants for the conveyor reject controller
package crc_pkg;

    localparam int TICKS_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        MODE_OFF = 2'd0,
        MODE_RUN = 2'd1,
        MODE_REJ = 2'd2,
        MODE_EMG = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_SPEED_UP  = 3'd1,
        CMD_SPEED_DN  = 3'd2,
        CMD_METAL_ON  = 3'd3,
        CMD_METAL_OFF = 3'd4,
        CMD_EMERGENCY = 3'd5,
        CMD_BUTTON    = 3'd6
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_SPEED    = 3'd0,
        REG_SPEED_STEP   = 3'd1,
        REG_MAX_SPEED    = 3'd2,
        REG_BASE_ANGLE   = 3'd3,
        REG_REJECT_ANGLE = 3'd4,
        REG_HOLD_TICKS   = 3'd5,
        REG_BLINK_TICKS  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [6:0]         min_speed;
        logic [6:0]         speed_step;
        logic [6:0]         max_speed;
        logic [7:0]         base_angle;
        logic [7:0]         reject_angle;
        logic [TICKS_W-1:0] hold_ticks;
        logic [TICKS_W-1:0] blink_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        min_speed:    7'd0,
        speed_step:   7'd10,
        max_speed:    7'd100,
        base_angle:   8'd90,
        reject_angle: 8'd45,
        hold_ticks:   16'd1000,
        blink_ticks:  16'd250
    };

    // control state apart from the two countdowns
    typedef struct packed {
        mode_t      mode;
        logic [6:0] speed;
        logic [7:0] angle;
        logic       hold_armed;
        logic       blink_phase;
        logic       led;
        logic       edge_mode;
    } ctl_state_t;

    localparam ctl_state_t CTL_RESET = '{
        mode:        MODE_OFF,
        speed:       7'd0,
        angle:       8'd0,
        hold_armed:  1'b0,
        blink_phase: 1'b0,
        led:         1'b0,
        edge_mode:   1'b0
    };

    typedef struct packed {
        mode_t      mode;
        logic [6:0] belt_speed;
        logic       motor_on;
        logic       speed_update;
        logic [7:0] servo_angle;
        logic       led_on;
        logic       edge_mode;
    } res_t;

endpackage

@@ hw/rtl/crc_cfg_regs.sv @@
// configuration register file for the conveyor reject controller
module crc_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [crc_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [crc_pkg::CFG_DATA_W-1:0]   wr_data,
    output crc_pkg::cfg_t                    cfg
);

    crc_pkg::cfg_t cfg_reg;
    crc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (crc_pkg::reg_index_t'(wr_index))
                crc_pkg::REG_MIN_SPEED:    cfg_next.min_speed    = wr_data[6:0];
                crc_pkg::REG_SPEED_STEP:   cfg_next.speed_step   = wr_data[6:0];
                crc_pkg::REG_MAX_SPEED:    cfg_next.max_speed    = wr_data[6:0];
                crc_pkg::REG_BASE_ANGLE:   cfg_next.base_angle   = wr_data[7:0];
                crc_pkg::REG_REJECT_ANGLE: cfg_next.reject_angle = wr_data[7:0];
                crc_pkg::REG_HOLD_TICKS:   cfg_next.hold_ticks   = wr_data[15:0];
                crc_pkg::REG_BLINK_TICKS:  cfg_next.blink_ticks  = wr_data[15:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= crc_pkg::CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/crc_step.sv @@
// next-state and result logic for one event of the conveyor reject controller
module crc_step #(
    parameter int TIMER_WIDTH = 16
) (
    input  crc_pkg::cfg_t           cfg,
    input  crc_pkg::ctl_state_t     state,
    input  logic [TIMER_WIDTH-1:0]  hold_count,
    input  logic [TIMER_WIDTH-1:0]  blink_count,
    input  crc_pkg::cmd_t           cmd,
    input  logic                    metal,
    output crc_pkg::ctl_state_t     state_next,
    output logic [TIMER_WIDTH-1:0]  hold_next,
    output logic [TIMER_WIDTH-1:0]  blink_next,
    output crc_pkg::res_t           result
);

    localparam logic [31:0] TMAX = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

    // saturate to the timer range, zero loads as one
    function automatic logic [TIMER_WIDTH-1:0] timer_load(
        input logic [crc_pkg::TICKS_W-1:0] ticks
    );
        logic [31:0] ext;
        logic [31:0] sat;
        ext = 32'(ticks);
        sat = (ext > TMAX) ? TMAX : ext;
        if (sat == 32'd0)
            sat = 32'd1;
        return sat[TIMER_WIDTH-1:0];
    endfunction

    logic [TIMER_WIDTH-1:0] hold_load;
    logic [TIMER_WIDTH-1:0] blink_load;
    logic [TIMER_WIDTH-1:0] hold_dec;
    logic [TIMER_WIDTH-1:0] blink_dec;
    logic [7:0]             start_sum;
    logic [7:0]             inc_sum;
    logic [7:0]             dec_floor;
    logic [6:0]             dec_speed;
    logic                   upd;
    logic                   active;

    assign hold_load  = timer_load(cfg.hold_ticks);
    assign blink_load = timer_load(cfg.blink_ticks);
    assign hold_dec   = (hold_count != '0) ? hold_count - 1'b1 : hold_count;
    assign blink_dec  = (blink_count != '0) ? blink_count - 1'b1 : blink_count;
    assign start_sum  = {1'b0, cfg.min_speed} + {1'b0, cfg.speed_step};
    assign inc_sum    = {1'b0, state.speed} + {1'b0, cfg.speed_step};
    assign dec_floor  = start_sum;
    assign dec_speed  = ({1'b0, state.speed} >= dec_floor) ? state.speed - cfg.speed_step
                                                           : cfg.min_speed;
    assign active     = (state.mode == crc_pkg::MODE_RUN) || (state.mode == crc_pkg::MODE_REJ);

    always_comb
    begin
        state_next = state;
        hold_next  = hold_count;
        blink_next = blink_count;
        upd        = 1'b0;

        // off state: every defined event parks the servo first
        if (state.mode == crc_pkg::MODE_OFF)
        begin
            unique case (cmd) inside
                crc_pkg::CMD_TICK, crc_pkg::CMD_SPEED_UP, crc_pkg::CMD_SPEED_DN,
                crc_pkg::CMD_METAL_ON, crc_pkg::CMD_METAL_OFF, crc_pkg::CMD_EMERGENCY,
                crc_pkg::CMD_BUTTON: state_next.angle = cfg.base_angle;
                default:             state_next.angle = state.angle;
            endcase
        end

        unique case (cmd)
            crc_pkg::CMD_EMERGENCY:
            begin
                state_next.speed      = 7'd0;
                state_next.angle      = 8'd0;
                state_next.hold_armed = 1'b0;
                hold_next             = '0;
                state_next.edge_mode  = 1'b1;
                blink_next            = blink_load;
                state_next.mode       = crc_pkg::MODE_EMG;
            end
            crc_pkg::CMD_TICK:
            begin
                if (state.mode == crc_pkg::MODE_EMG)
                begin
                    if (blink_dec == '0)
                    begin
                        state_next.blink_phase = ~state.blink_phase;
                        state_next.led         = ~state.blink_phase;
                        blink_next             = blink_load;
                    end
                    else
                        blink_next = blink_dec;
                end
                if (state.hold_armed)
                begin
                    hold_next = hold_dec;
                    if (hold_dec == '0)
                    begin
                        state_next.hold_armed = 1'b0;
                        if (state.mode == crc_pkg::MODE_REJ)
                        begin
                            if (metal)
                            begin
                                hold_next             = hold_load;
                                state_next.hold_armed = 1'b1;
                            end
                            else
                            begin
                                state_next.angle = cfg.base_angle;
                                state_next.mode  = crc_pkg::MODE_RUN;
                            end
                        end
                    end
                end
            end
            crc_pkg::CMD_SPEED_UP:
            begin
                if (state.mode == crc_pkg::MODE_OFF)
                begin
                    state_next.speed = start_sum[7] ? 7'd127 : start_sum[6:0];
                    state_next.mode  = crc_pkg::MODE_RUN;
                    upd              = 1'b1;
                end
                else if (active)
                begin
                    state_next.speed = (inc_sum <= {1'b0, cfg.max_speed}) ? inc_sum[6:0]
                                                                         : cfg.max_speed;
                    upd              = 1'b1;
                end
            end
            crc_pkg::CMD_SPEED_DN:
            begin
                if (active)
                begin
                    state_next.speed = dec_speed;
                    upd              = 1'b1;
                    if (dec_speed <= cfg.min_speed)
                    begin
                        state_next.hold_armed = 1'b0;
                        hold_next             = '0;
                        state_next.angle      = 8'd0;
                        state_next.mode       = crc_pkg::MODE_OFF;
                    end
                end
            end
            crc_pkg::CMD_METAL_ON:
            begin
                if (state.mode == crc_pkg::MODE_RUN)
                begin
                    state_next.angle      = cfg.reject_angle;
                    hold_next             = hold_load;
                    state_next.hold_armed = 1'b1;
                    state_next.mode       = crc_pkg::MODE_REJ;
                end
            end
            crc_pkg::CMD_BUTTON:
            begin
                if (state.mode == crc_pkg::MODE_EMG)
                begin
                    blink_next           = '0;
                    state_next.edge_mode = 1'b0;
                    state_next.led       = 1'b0;
                    state_next.speed     = cfg.min_speed;
                    state_next.angle     = cfg.base_angle;
                    state_next.mode      = crc_pkg::MODE_OFF;
                end
            end
            default:
            begin
                upd = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result.mode         = state_next.mode;
        result.belt_speed   = state_next.speed;
        result.motor_on     = state_next.speed > cfg.min_speed;
        result.speed_update = upd;
        result.servo_angle  = state_next.angle;
        result.led_on       = state_next.led;
        result.edge_mode    = state_next.edge_mode;
    end

endmodule

@@ hw/rtl/conveyor_reject_controller.sv @@
// top level of the conveyor reject controller: event register, state update, result register
// a request accepted into the input register passes through crc_step into the result register behind m_tvalid
// throughput: one request per cycle while m_tready is high; the input register refills while the result is taken
// the state update is one pass of compare, add and select in crc_step between two registers
// reset (rst_n low, asynchronous): mode off, speed, servo, timers and led cleared,
// configuration registers back to their defaults, both stream sides empty
module conveyor_reject_controller #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // event stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [crc_pkg::IN_TDATA_W-1:0]      s_tdata,   // cmd[2:0], metal_present[3]
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [crc_pkg::OUT_TDATA_W-1:0]     m_tdata,   // mode[1:0], belt_speed[8:2],
                                                           // motor_on[9], speed_update[10],
                                                           // servo_angle[18:11], led_on[19],
                                                           // edge_mode[20]
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [crc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [crc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // configuration registers, always ready to take a write
    crc_pkg::cfg_t cfg;

    assign cfg_ready = 1'b1;

    crc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // input register holding one event request
    logic          in_valid_reg;
    crc_pkg::cmd_t in_cmd_reg;
    logic          in_metal_reg;

    // controller state
    crc_pkg::ctl_state_t    state_reg;
    crc_pkg::ctl_state_t    state_next;
    logic [TIMER_WIDTH-1:0] hold_count_reg;
    logic [TIMER_WIDTH-1:0] hold_count_next;
    logic [TIMER_WIDTH-1:0] blink_count_reg;
    logic [TIMER_WIDTH-1:0] blink_count_next;

    // result register
    logic          out_valid_reg;
    crc_pkg::res_t res_reg;
    crc_pkg::res_t res_next;

    // the held event moves on when the result slot is empty or being emptied
    logic advance;
    logic s_accept;

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign s_accept = s_tvalid & s_tready;

    crc_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .cfg         (cfg),
        .state       (state_reg),
        .hold_count  (hold_count_reg),
        .blink_count (blink_count_reg),
        .cmd         (in_cmd_reg),
        .metal       (in_metal_reg),
        .state_next  (state_next),
        .hold_next   (hold_count_next),
        .blink_next  (blink_count_next),
        .result      (res_next)
    );

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_cmd_reg   <= crc_pkg::cmd_t'(s_tdata[2:0]);
            in_metal_reg <= s_tdata[3];
        end
    end

    // state only changes when an event is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= crc_pkg::CTL_RESET;
            hold_count_reg  <= '0;
            blink_count_reg <= '0;
        end
        else if (advance)
        begin
            state_reg       <= state_next;
            hold_count_reg  <= hold_count_next;
            blink_count_reg <= blink_count_next;
        end
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_reg.edge_mode, res_reg.led_on, res_reg.servo_angle,
                       res_reg.speed_update, res_reg.motor_on, res_reg.belt_speed,
                       res_reg.mode};

    // the reject hold only runs while ejecting
    a_hold_only_rejecting : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.hold_armed |-> state_reg.mode == crc_pkg::MODE_REJ)
        else $error("reject hold armed outside rejecting mode");

    // edge mode is requested exactly while in emergency stop
    a_edge_mode_tracks_emg : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.edge_mode == (state_reg.mode == crc_pkg::MODE_EMG))
        else $error("edge mode out of step with emergency mode");

    // emergency stop always reports a stopped belt
    a_emg_belt_stopped : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_reg.mode == crc_pkg::MODE_EMG) |-> res_reg.belt_speed == 7'd0)
        else $error("belt speed nonzero in emergency stop");

    // a processed event always produces a result in the next cycle
    a_advance_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed request produced no result");

endmodule

@@ bench/tb_conveyor_reject_controller.sv @@
// self-checking bench for the conveyor reject controller: event stream in, status stream out
`timescale 1ns / 100ps

module tb_conveyor_reject_controller;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_EVENTS = 80;
    localparam int MAX_REPORTS = 10;
    // the one command code the block has no name for, it must change nothing
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // belt status tracker: own copy of registers and control state, queue of expected status
    class belt_status_tracker;
        logic [6:0]  min_speed, speed_step, max_speed;
        logic [7:0]  base_angle, reject_angle;
        logic [15:0] hold_ticks, blink_ticks;

        crc_pkg::mode_t mode;
        logic [6:0]  speed;
        logic [7:0]  angle;
        logic [15:0] hold_count, blink_count;
        logic        hold_armed, blink_phase, led, edge_mode;

        crc_pkg::res_t expected_status[$];
        int          errors;

        function new();
            min_speed = crc_pkg::CFG_RESET.min_speed;
            speed_step = crc_pkg::CFG_RESET.speed_step;
            max_speed = crc_pkg::CFG_RESET.max_speed;
            base_angle = crc_pkg::CFG_RESET.base_angle;
            reject_angle = crc_pkg::CFG_RESET.reject_angle;
            hold_ticks = crc_pkg::CFG_RESET.hold_ticks;
            blink_ticks = crc_pkg::CFG_RESET.blink_ticks;
            mode = crc_pkg::MODE_OFF;
            speed = crc_pkg::CFG_RESET.min_speed;
            angle = '0;
            hold_count = '0;
            blink_count = '0;
            hold_armed = 1'b0;
            blink_phase = 1'b0;
            led = 1'b0;
            edge_mode = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(crc_pkg::reg_index_t idx, logic [15:0] value);
            case (idx)
                crc_pkg::REG_MIN_SPEED:    min_speed = value[6:0];
                crc_pkg::REG_SPEED_STEP:   speed_step = value[6:0];
                crc_pkg::REG_MAX_SPEED:    max_speed = value[6:0];
                crc_pkg::REG_BASE_ANGLE:   base_angle = value[7:0];
                crc_pkg::REG_REJECT_ANGLE: reject_angle = value[7:0];
                crc_pkg::REG_HOLD_TICKS:   hold_ticks = value;
                crc_pkg::REG_BLINK_TICKS:  blink_ticks = value;
                default: ;
            endcase
        endfunction

        // a zero count would never expire, so it loads as one
        function logic [15:0] load_count(logic [15:0] ticks);
            return (ticks == 16'd0) ? 16'd1 : ticks;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        // advance the state by one accepted event and queue the status it yields
        function void note_event(logic [2:0] cmd, logic metal);
            crc_pkg::res_t st;
            logic upd;
            int   start;
            upd = 1'b0;
            if (cmd <= crc_pkg::CMD_BUTTON && mode == crc_pkg::MODE_OFF)
                angle = base_angle;
            case (cmd)
                crc_pkg::CMD_EMERGENCY:
                begin
                    speed = '0;
                    angle = '0;
                    hold_armed = 1'b0;
                    hold_count = '0;
                    edge_mode = 1'b1;
                    blink_count = load_count(blink_ticks);
                    mode = crc_pkg::MODE_EMG;
                end
                crc_pkg::CMD_TICK:
                begin
                    if (mode == crc_pkg::MODE_EMG)
                    begin
                        if (blink_count > 0)
                            blink_count = blink_count - 1'b1;
                        if (blink_count == 0)
                        begin
                            blink_phase = ~blink_phase;
                            led = blink_phase;
                            blink_count = load_count(blink_ticks);
                        end
                    end
                    if (hold_armed)
                    begin
                        if (hold_count > 0)
                            hold_count = hold_count - 1'b1;
                        if (hold_count == 0)
                        begin
                            hold_armed = 1'b0;
                            // hold expiry only matters while rejecting
                            if (mode == crc_pkg::MODE_REJ)
                            begin
                                if (metal)
                                begin
                                    hold_count = load_count(hold_ticks);
                                    hold_armed = 1'b1;
                                end
                                else
                                begin
                                    angle = base_angle;
                                    mode = crc_pkg::MODE_RUN;
                                end
                            end
                        end
                    end
                end
                crc_pkg::CMD_SPEED_UP:
                begin
                    if (mode == crc_pkg::MODE_OFF)
                    begin
                        start = int'(min_speed) + int'(speed_step);
                        speed = (start > 127) ? 7'd127 : start[6:0];
                        mode = crc_pkg::MODE_RUN;
                        upd = 1'b1;
                    end
                    else if (mode == crc_pkg::MODE_RUN || mode == crc_pkg::MODE_REJ)
                    begin
                        if (int'(speed) + int'(speed_step) <= int'(max_speed))
                            speed = speed + speed_step;
                        else
                            speed = max_speed;
                        upd = 1'b1;
                    end
                end
                crc_pkg::CMD_SPEED_DN:
                begin
                    if (mode == crc_pkg::MODE_RUN || mode == crc_pkg::MODE_REJ)
                    begin
                        if (int'(speed) >= int'(min_speed) + int'(speed_step))
                            speed = speed - speed_step;
                        else
                            speed = min_speed;
                        if (speed <= min_speed)
                        begin
                            hold_armed = 1'b0;
                            hold_count = '0;
                            angle = '0;
                            mode = crc_pkg::MODE_OFF;
                        end
                        upd = 1'b1;
                    end
                end
                crc_pkg::CMD_METAL_ON:
                begin
                    if (mode == crc_pkg::MODE_RUN)
                    begin
                        angle = reject_angle;
                        hold_count = load_count(hold_ticks);
                        hold_armed = 1'b1;
                        mode = crc_pkg::MODE_REJ;
                    end
                end
                crc_pkg::CMD_BUTTON:
                begin
                    if (mode == crc_pkg::MODE_EMG)
                    begin
                        blink_count = '0;
                        edge_mode = 1'b0;
                        led = 1'b0;
                        speed = min_speed;
                        angle = base_angle;
                        mode = crc_pkg::MODE_OFF;
                    end
                end
                default: ;
            endcase
            st.mode = mode;
            st.belt_speed = speed;
            st.motor_on = (speed > min_speed);
            st.speed_update = upd;
            st.servo_angle = angle;
            st.led_on = led;
            st.edge_mode = edge_mode;
            expected_status.push_back(st);
        endfunction

        // compare one returned status word with the oldest expectation
        function void check_result(logic [crc_pkg::OUT_TDATA_W-1:0] d);
            crc_pkg::res_t st;
            if (expected_status.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("status with no event pending: %h", d);
                return;
            end
            st = expected_status.pop_front();
            if (d[1:0] !== st.mode || d[8:2] !== st.belt_speed || d[9] !== st.motor_on
                || d[10] !== st.speed_update || d[18:11] !== st.servo_angle
                || d[19] !== st.led_on || d[20] !== st.edge_mode)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"status mismatch: expected mode %0d speed %0d motor %0b upd %0b",
                              " servo %0d led %0b edge %0b, got mode %0d speed %0d motor %0b",
                              " upd %0b servo %0d led %0b edge %0b"},
                             st.mode, st.belt_speed, st.motor_on, st.speed_update,
                             st.servo_angle, st.led_on, st.edge_mode,
                             d[1:0], d[8:2], d[9], d[10], d[18:11], d[19], d[20]);
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [crc_pkg::IN_TDATA_W-1:0]  s_tdata;   // cmd[2:0], metal_present[3]
    logic                            m_tvalid;
    logic                            m_tready;
    logic [crc_pkg::OUT_TDATA_W-1:0] m_tdata;   // mode, belt_speed, motor_on, speed_update,
                                                // servo_angle, led_on, edge_mode
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [crc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [crc_pkg::CFG_DATA_W-1:0]  cfg_data;

    belt_status_tracker     tracker;
    int                     cycles;
    // sender pacing: a run of requests either back to back or with random gaps
    int                     tx_left;
    bit                     tx_calm;

    conveyor_reject_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_conveyor_reject_controller NOT OK");
            $finish;
        end
    end

    // one register write request, held until the block takes it
    task automatic write_reg(crc_pkg::reg_index_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(idx, value);
    endtask

    task automatic apply_config(crc_pkg::cfg_t c);
        write_reg(crc_pkg::REG_MIN_SPEED, 16'(c.min_speed));
        write_reg(crc_pkg::REG_SPEED_STEP, 16'(c.speed_step));
        write_reg(crc_pkg::REG_MAX_SPEED, 16'(c.max_speed));
        write_reg(crc_pkg::REG_BASE_ANGLE, 16'(c.base_angle));
        write_reg(crc_pkg::REG_REJECT_ANGLE, 16'(c.reject_angle));
        write_reg(crc_pkg::REG_HOLD_TICKS, c.hold_ticks);
        write_reg(crc_pkg::REG_BLINK_TICKS, c.blink_ticks);
        cfg_valid <= 1'b0;
    endtask

    // send one event request; valid stays up afterwards so the next one can follow at once
    task automatic send_event(logic [2:0] cmd, logic metal);
        int gap;
        if (tx_left == 0)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            tx_left = $urandom_range(10, 40);
        end
        tx_left--;
        gap = tx_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= {4'b0000, metal, cmd};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        tracker.note_event(cmd, metal);
    endtask

    task automatic stop_events();
        s_tvalid <= 1'b0;
    endtask

    // wait until every status has come back, then let the pipeline settle
    task automatic drain();
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // random event mix: ticks dominate so holds and blinks expire, starts and
    // metal hits keep the belt busy, a few button presses and emergencies
    task automatic send_random_event();
        int         r;
        logic [2:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 38)
            cmd = crc_pkg::CMD_TICK;
        else if (r < 50)
            cmd = crc_pkg::CMD_SPEED_UP;
        else if (r < 58)
            cmd = crc_pkg::CMD_SPEED_DN;
        else if (r < 70)
            cmd = crc_pkg::CMD_METAL_ON;
        else if (r < 75)
            cmd = crc_pkg::CMD_METAL_OFF;
        else if (r < 80)
            cmd = crc_pkg::CMD_EMERGENCY;
        else if (r < 97)
            cmd = crc_pkg::CMD_BUTTON;
        else
            cmd = CMD_UNUSED;
        send_event(cmd, ($urandom_range(0, 99) < 55));
    endtask

    // result side: random stalls, with calm stretches where every status is taken at once
    initial
    begin
        int stall;
        int rx_left;
        bit rx_calm;
        rx_left = 0;
        rx_calm = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_left == 0)
            begin
                rx_calm = ($urandom_range(0, 3) == 0);
                rx_left = $urandom_range(10, 40);
            end
            rx_left--;
            stall = rx_calm ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            tracker.check_result(m_tdata);
        end
    end

    initial
    begin
        crc_pkg::cfg_t phases[5];
        crc_pkg::cfg_t rnd_cfg;
        crc_pkg::cfg_t dir_cfg;
        logic [2:0]    dir_cmd[25];
        logic          dir_metal[25];

        tracker = new();
        cycles = 0;
        tx_left = 0;
        tx_calm = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = crc_pkg::REG_MIN_SPEED;
        cfg_data = '0;

        // defaults, slowest step, inverted speed limits with start overflow,
        // longest timers, zero timer loads
        phases[0] = crc_pkg::CFG_RESET;
        phases[1] = '{min_speed: 7'd0, speed_step: 7'd1, max_speed: 7'd100,
                      base_angle: 8'd0, reject_angle: 8'd180,
                      hold_ticks: 16'd1, blink_ticks: 16'd1};
        phases[2] = '{min_speed: 7'd100, speed_step: 7'd100, max_speed: 7'd0,
                      base_angle: 8'd180, reject_angle: 8'd0,
                      hold_ticks: 16'd3, blink_ticks: 16'd4};
        phases[3] = '{min_speed: 7'd5, speed_step: 7'd7, max_speed: 7'd60,
                      base_angle: 8'd45, reject_angle: 8'd135,
                      hold_ticks: 16'd65535, blink_ticks: 16'd65535};
        phases[4] = '{min_speed: 7'd0, speed_step: 7'd100, max_speed: 7'd100,
                      base_angle: 8'd90, reject_angle: 8'd90,
                      hold_ticks: 16'd0, blink_ticks: 16'd0};

        dir_cfg = '{min_speed: 7'd20, speed_step: 7'd50, max_speed: 7'd100,
                    base_angle: 8'd180, reject_angle: 8'd0,
                    hold_ticks: 16'd0, blink_ticks: 16'd2};
        // ignored events while off, start, clamp at max, reject with re-arm and
        // expiry, decrement into off, emergency from off and running, blinking,
        // repeated emergency, button release, unused code
        dir_cmd = '{crc_pkg::CMD_TICK, crc_pkg::CMD_BUTTON, crc_pkg::CMD_METAL_ON,
                    CMD_UNUSED, crc_pkg::CMD_SPEED_DN, crc_pkg::CMD_SPEED_UP,
                    crc_pkg::CMD_SPEED_UP, crc_pkg::CMD_METAL_OFF, crc_pkg::CMD_METAL_ON,
                    crc_pkg::CMD_TICK, crc_pkg::CMD_TICK, crc_pkg::CMD_METAL_ON,
                    crc_pkg::CMD_BUTTON, crc_pkg::CMD_SPEED_DN, crc_pkg::CMD_SPEED_DN,
                    crc_pkg::CMD_EMERGENCY, crc_pkg::CMD_TICK, crc_pkg::CMD_TICK,
                    crc_pkg::CMD_EMERGENCY, crc_pkg::CMD_SPEED_UP, crc_pkg::CMD_BUTTON,
                    crc_pkg::CMD_SPEED_UP, crc_pkg::CMD_EMERGENCY, crc_pkg::CMD_BUTTON,
                    CMD_UNUSED};
        dir_metal = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
                      1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                      1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        apply_config(dir_cfg);
        foreach (dir_cmd[i])
            send_event(dir_cmd[i], dir_metal[i]);
        stop_events();
        drain();

        // random part: fixed settings first, then one drawn at random
        for (int p = 0; p < 6; p++)
        begin
            if (p < 5)
                apply_config(phases[p]);
            else
            begin
                rnd_cfg.min_speed = 7'($urandom_range(0, 100));
                rnd_cfg.speed_step = 7'($urandom_range(1, 100));
                rnd_cfg.max_speed = 7'($urandom_range(0, 100));
                rnd_cfg.base_angle = 8'($urandom_range(0, 180));
                rnd_cfg.reject_angle = 8'($urandom_range(0, 180));
                rnd_cfg.hold_ticks = 16'($urandom_range(1, 6));
                rnd_cfg.blink_ticks = 16'($urandom_range(1, 6));
                apply_config(rnd_cfg);
            end
            for (int i = 0; i < PHASE_EVENTS; i++)
            begin
                // halfway through, hold off until the block has answered everything
                if (i == PHASE_EVENTS / 2)
                begin
                    stop_events();
                    drain();
                end
                send_random_event();
            end
            stop_events();
            drain();
        end

        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb_conveyor_reject_controller OK");
        else
            $display("tb_conveyor_reject_controller NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/crc_pkg.sv
hw/rtl/crc_cfg_regs.sv
hw/rtl/crc_step.sv
hw/rtl/conveyor_reject_controller.sv
bench/tb_conveyor_reject_controller.sv
